[hw/rtl/prot_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package prot_pkg;

   localparam int SES_W = 5;
   localparam int HND_W = 7;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] CMD_ADD      = 2'd0;
   localparam logic [1:0] CMD_TAKE     = 2'd1;
   localparam logic [1:0] CMD_FREE_ALL = 2'd2;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_BUSY        = 2'd1;
   localparam logic [1:0] ST_NOT_PENDING = 2'd2;

   // Decoded operations handed from the front end to the back end.
   localparam logic [1:0] OP_IMM  = 2'd0;
   localparam logic [1:0] OP_ADD  = 2'd1;
   localparam logic [1:0] OP_TAKE = 2'd2;
   localparam logic [1:0] OP_FREE = 2'd3;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [SES_W-1:0] session;
      logic [HND_W-1:0] request_handle;
   } req_type;

   typedef struct packed {
      logic [SES_W-1:0] owner_session;
      logic [1:0]       status;
      logic [7:0]       removed_count;
      logic [7:0]       pending_left;
   } rsp_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [1:0]       imm_status;
      logic             hnd_ok;
      logic [SES_W-1:0] session;
      logic [HND_W-1:0] handle;
   } op_type;

   typedef struct packed {
      logic             valid;
      logic [SES_W-1:0] owner;
   } ent_type;

   function automatic logic [7:0] sat8(input logic [31:0] v);
      logic [7:0] r;
      r = (v > 32'd255) ? 8'd255 : v[7:0];
      return r;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/prot_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module prot_front import prot_pkg::*; #(
   parameter int HANDLE_DEPTH  = 128,
   parameter int SESSION_COUNT = 32
) (
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   input  wire logic    q_full,
   input  wire logic    back_ready,
   output logic         push,
   output op_type       push_op
);

   logic ses_ok;
   logic hnd_ok;

   assign ses_ok = 32'(req_item.session) < 32'(SESSION_COUNT);
   assign hnd_ok = 32'(req_item.request_handle) < 32'(HANDLE_DEPTH);

   assign busy = q_full || !back_ready;
   assign push = start && !busy;

   // Requests that can be answered without touching the tables are turned
   // into immediate replies here; the back end passes them on as results.
   always_comb begin
      push_op.op = OP_IMM;
      push_op.imm_status = ST_OK;
      push_op.hnd_ok = hnd_ok;
      push_op.session = req_item.session;
      push_op.handle = req_item.request_handle;
      case (req_item.cmd)
         CMD_ADD: begin
            if (ses_ok) begin
               push_op.op = OP_ADD;
            end else begin
               push_op.imm_status = ST_BUSY;
            end
         end
         CMD_TAKE: begin
            if (hnd_ok) begin
               push_op.op = OP_TAKE;
            end else begin
               push_op.imm_status = ST_NOT_PENDING;
            end
         end
         CMD_FREE_ALL: begin
            if (ses_ok) begin
               push_op.op = OP_FREE;
            end
         end
         default: begin
            push_op.op = OP_IMM;
         end
      endcase
   end

endmodule

`default_nettype wire

[hw/rtl/prot_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module prot_queue import prot_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire op_type push_op,
   input  wire logic   pop,
   output logic        full,
   output logic        head_valid,
   output op_type      head_op
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   op_type             slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_op = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/prot_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module prot_back import prot_pkg::*; #(
   parameter int HANDLE_DEPTH  = 128,
   parameter int SESSION_COUNT = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   head_valid,
   input  wire op_type head_op,
   output logic        pop,
   output logic        back_ready,
   output logic        rsp_valid,
   output rsp_type     rsp_item
);

   localparam int HIDX_W = $clog2(HANDLE_DEPTH);
   localparam int SIDX_W = $clog2(SESSION_COUNT);
   localparam int CNT_W  = $clog2(HANDLE_DEPTH + 1);
   localparam int CLR_N  = (HANDLE_DEPTH > SESSION_COUNT) ? HANDLE_DEPTH : SESSION_COUNT;
   localparam int CLR_W  = $clog2(CLR_N);

   localparam logic [2:0] S_CLEAR    = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_ADD      = 3'd2;
   localparam logic [2:0] S_TAKE_ENT = 3'd3;
   localparam logic [2:0] S_TAKE_CNT = 3'd4;
   localparam logic [2:0] S_FA_CNT   = 3'd5;
   localparam logic [2:0] S_FA_SCAN  = 3'd6;

   ent_type            ent_mem_ff [HANDLE_DEPTH];
   logic [CNT_W-1:0]   cnt_mem_ff [SESSION_COUNT];
   ent_type            ent_rd_ff;
   logic [CNT_W-1:0]   cnt_rd_ff;

   logic [2:0]         state_ff, state_in;
   op_type             cur_ff, cur_in;
   logic [CLR_W-1:0]   clr_idx_ff, clr_idx_in;
   logic [HIDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   freed_ff, freed_in;
   logic [SES_W-1:0]   owner_ff, owner_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [HIDX_W-1:0]  ent_raddr;
   logic               ent_we;
   logic [HIDX_W-1:0]  ent_waddr;
   ent_type            ent_wdata;
   logic [SIDX_W-1:0]  cnt_raddr;
   logic               cnt_we;
   logic [SIDX_W-1:0]  cnt_waddr;
   logic [CNT_W-1:0]   cnt_wdata;

   logic               hit;
   logic [CNT_W-1:0]   cnt_next;
   logic [CNT_W-1:0]   freed_next;
   logic [CNT_W-1:0]   cnt_dec;

   assign hit = ent_rd_ff.valid && (ent_rd_ff.owner == cur_ff.session);
   assign cnt_next = cnt_ff - CNT_W'(hit);
   assign freed_next = freed_ff + CNT_W'(hit);
   assign cnt_dec = (cnt_rd_ff != '0) ? cnt_rd_ff - CNT_W'(1) : cnt_rd_ff;

   assign back_ready = (state_ff != S_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      clr_idx_in = clr_idx_ff;
      scan_idx_in = scan_idx_ff;
      cnt_in = cnt_ff;
      freed_in = freed_ff;
      owner_in = owner_ff;
      rsp_valid_in = 1'b0;
      rsp_in = '0;
      pop = 1'b0;
      ent_raddr = HIDX_W'(head_op.handle);
      ent_we = 1'b0;
      ent_waddr = HIDX_W'(cur_ff.handle);
      ent_wdata = '0;
      cnt_raddr = SIDX_W'(head_op.session);
      cnt_we = 1'b0;
      cnt_waddr = SIDX_W'(cur_ff.session);
      cnt_wdata = '0;

      case (state_ff)
         S_CLEAR: begin
            ent_we = 1'b1;
            ent_waddr = HIDX_W'(clr_idx_ff);
            cnt_we = 1'b1;
            cnt_waddr = SIDX_W'(clr_idx_ff);
            if (clr_idx_ff == CLR_W'(CLR_N - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + CLR_W'(1);
            end
         end
         S_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               cur_in = head_op;
               case (head_op.op)
                  OP_ADD: begin
                     state_in = S_ADD;
                  end
                  OP_TAKE: begin
                     state_in = S_TAKE_ENT;
                  end
                  OP_FREE: begin
                     state_in = S_FA_CNT;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in.status = head_op.imm_status;
                  end
               endcase
            end
         end
         S_ADD: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
            if (!cur_ff.hnd_ok || ent_rd_ff.valid) begin
               rsp_in.status = ST_BUSY;
               rsp_in.pending_left = sat8(32'(cnt_rd_ff));
            end else begin
               ent_we = 1'b1;
               ent_wdata.valid = 1'b1;
               ent_wdata.owner = cur_ff.session;
               cnt_we = 1'b1;
               cnt_wdata = cnt_rd_ff + CNT_W'(1);
               rsp_in.status = ST_OK;
               rsp_in.pending_left = sat8(32'(cnt_rd_ff) + 32'd1);
            end
         end
         S_TAKE_ENT: begin
            if (!ent_rd_ff.valid) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = ST_NOT_PENDING;
               state_in = S_IDLE;
            end else begin
               ent_we = 1'b1;
               cnt_raddr = SIDX_W'(ent_rd_ff.owner);
               owner_in = ent_rd_ff.owner;
               state_in = S_TAKE_CNT;
            end
         end
         S_TAKE_CNT: begin
            cnt_we = 1'b1;
            cnt_waddr = SIDX_W'(owner_ff);
            cnt_wdata = cnt_dec;
            rsp_valid_in = 1'b1;
            rsp_in.owner_session = owner_ff;
            rsp_in.status = ST_OK;
            rsp_in.removed_count = 8'd1;
            rsp_in.pending_left = sat8(32'(cnt_dec));
            state_in = S_IDLE;
         end
         S_FA_CNT: begin
            cnt_in = cnt_rd_ff;
            freed_in = '0;
            if (cnt_rd_ff == '0) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               ent_raddr = '0;
               scan_idx_in = '0;
               state_in = S_FA_SCAN;
            end
         end
         S_FA_SCAN: begin
            // The read of the next entry overlaps the check of this one.
            ent_waddr = scan_idx_ff;
            ent_we = hit;
            if ((cnt_next == '0) || (scan_idx_ff == HIDX_W'(HANDLE_DEPTH - 1))) begin
               cnt_we = 1'b1;
               cnt_wdata = cnt_next;
               rsp_valid_in = 1'b1;
               rsp_in.status = ST_OK;
               rsp_in.removed_count = sat8(32'(freed_next));
               rsp_in.pending_left = sat8(32'(cnt_next));
               state_in = S_IDLE;
            end else begin
               ent_raddr = scan_idx_ff + HIDX_W'(1);
               scan_idx_in = scan_idx_ff + HIDX_W'(1);
               cnt_in = cnt_next;
               freed_in = freed_next;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_idx_ff <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      scan_idx_ff <= scan_idx_in;
      cnt_ff <= cnt_in;
      freed_ff <= freed_in;
      owner_ff <= owner_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem_ff[ent_waddr] <= ent_wdata;
      end
      ent_rd_ff <= ent_mem_ff[ent_raddr];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem_ff[cnt_waddr] <= cnt_wdata;
      end
      cnt_rd_ff <= cnt_mem_ff[cnt_raddr];
   end

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid_ff)
      else $error("response issued during the clearing pass");

   a_rsp_ends_in_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("response issued while a command is still in progress");

   a_scan_count_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FA_SCAN) |-> (cnt_ff != '0))
      else $error("free-all scan running with no pending handles left");

   a_take_frees_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ($past(state_ff) == S_TAKE_CNT)) |-> (rsp_ff.removed_count == 8'd1))
      else $error("successful take did not report one freed handle");

endmodule

`default_nettype wire

[hw/rtl/pending_request_owner_table_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Pending request owner table.
// Input channel: drive req_item with start high; the item is taken at a clock edge where
// start is high and busy is low. Commands are add, take and free-all of a session.
// Result channel: each item gives exactly one result, shown on rsp_item for a single cycle
// with rsp_valid high. The receiver cannot stall, so results are never held back.
// Items pass through a two-entry queue between the decoder and the table engine, so busy
// rises only when that queue is full or the tables are being cleared.
// The table engine handles one item at a time while later items wait in the queue.
// Free-all scans up to HANDLE_DEPTH handles, since the handle table has one read port and
// is walked one entry a cycle from index 0.
// Commands rejected by the decoder and unused ones are answered from the idle state; add
// reads the handle entry and the session count, take reads the entry and then the owner's
// count, and free-all reads the count and then scans. A result is held back while earlier
// items are still queued or in progress.
// Reset: after reset is released the handle table and the session counts are cleared,
// one entry a cycle, over the larger of HANDLE_DEPTH and SESSION_COUNT entries; busy stays
// high for that time and then every handle is free and every count is zero.
module pending_request_owner_table_top import prot_pkg::*; #(
   parameter int HANDLE_DEPTH  = 128,
   parameter int SESSION_COUNT = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);

   logic   q_full;
   logic   back_ready;
   logic   push;
   op_type push_op;
   logic   pop;
   logic   head_valid;
   op_type head_op;

   prot_front #(
      .HANDLE_DEPTH  (HANDLE_DEPTH),
      .SESSION_COUNT (SESSION_COUNT)
   ) u_front (
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .q_full     (q_full),
      .back_ready (back_ready),
      .push       (push),
      .push_op    (push_op)
   );

   prot_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (push_op),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_op    (head_op)
   );

   prot_back #(
      .HANDLE_DEPTH  (HANDLE_DEPTH),
      .SESSION_COUNT (SESSION_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_op    (head_op),
      .pop        (pop),
      .back_ready (back_ready),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import prot_pkg::*;

   localparam int HANDLE_DEPTH  = 128;
   localparam int SESSION_COUNT = 32;
   localparam int ITEM_TARGET   = 1850;
   localparam int DRAIN_CYCLES  = 200;
   localparam int RUN_LIMIT     = 1500000;

   typedef struct {
      req_type item;
      int      gap;
   } cmd_slot_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;

   // Table contents as the block should hold them, updated at item acceptance.
   logic       tbl_valid [HANDLE_DEPTH];
   logic [4:0] tbl_owner [HANDLE_DEPTH];
   int         ses_count [SESSION_COUNT];

   // Occupancy as seen while the command list is planned; -1 means free.
   int plan_owner [HANDLE_DEPTH];

   cmd_slot_type plan_q[$];
   rsp_type   outcome_q[$];
   int        errors    = 0;
   int        cycle_cnt = 0;
   int        idle_run  = 0;
   int        burst_left = 0;

   pending_request_owner_table_top #(
      .HANDLE_DEPTH (HANDLE_DEPTH),
      .SESSION_COUNT(SESSION_COUNT)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   always #5 clock = ~clock;

   always @(posedge clock) cycle_cnt <= cycle_cnt + 1;

   function automatic logic [7:0] clip8(input int v);
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   // Applies one command to the table copy and returns the result it must produce.
   function automatic rsp_type table_outcome(input req_type it);
      rsp_type o;
      int      s;
      int      h;
      int      own;
      int      freed;
      int      i;
      o     = '0;
      s     = int'(it.session);
      h     = int'(it.request_handle);
      freed = 0;
      case (it.cmd)
         CMD_ADD: begin
            if (tbl_valid[h]) begin
               o.status = ST_BUSY;
            end else begin
               tbl_valid[h] = 1'b1;
               tbl_owner[h] = it.session;
               ses_count[s]++;
               o.status = ST_OK;
            end
            o.pending_left = clip8(ses_count[s]);
         end
         CMD_TAKE: begin
            if (!tbl_valid[h]) begin
               o.status = ST_NOT_PENDING;
            end else begin
               own          = int'(tbl_owner[h]);
               tbl_valid[h] = 1'b0;
               if (ses_count[own] > 0) ses_count[own]--;
               o.status        = ST_OK;
               o.owner_session = tbl_owner[h];
               o.removed_count = 8'd1;
               o.pending_left  = clip8(ses_count[own]);
            end
         end
         CMD_FREE_ALL: begin
            // The scan stops as soon as the session has nothing left pending.
            for (i = 0; i < HANDLE_DEPTH && ses_count[s] > 0; i++) begin
               if (tbl_valid[i] && tbl_owner[i] == it.session) begin
                  tbl_valid[i] = 1'b0;
                  ses_count[s]--;
                  freed++;
               end
            end
            o.status        = ST_OK;
            o.removed_count = clip8(freed);
            o.pending_left  = clip8(ses_count[s]);
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic int pick_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 199);
      if (r == 0) begin
         burst_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 100) return 0;
      if (r < 170) return $urandom_range(1, 3);
      if (r < 194) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Returns a random handle that is pending (want_busy) or free, or -1 if there is none.
   function automatic int pick_handle(input bit want_busy);
      int n;
      int k;
      int i;
      n = 0;
      for (i = 0; i < HANDLE_DEPTH; i++) if ((plan_owner[i] >= 0) == want_busy) n++;
      if (n == 0) return -1;
      k = $urandom_range(0, n - 1);
      for (i = 0; i < HANDLE_DEPTH; i++) begin
         if ((plan_owner[i] >= 0) == want_busy) begin
            if (k == 0) return i;
            k--;
         end
      end
      return -1;
   endfunction

   task automatic plan_cmd(input logic [1:0] c, input int s, input int h);
      cmd_slot_type slot;
      int        i;
      slot.item.cmd            = c;
      slot.item.session        = s[4:0];
      slot.item.request_handle = h[6:0];
      slot.gap                 = pick_gap();
      plan_q.push_back(slot);
      case (c)
         CMD_ADD:  if (plan_owner[h] < 0) plan_owner[h] = s;
         CMD_TAKE: plan_owner[h] = -1;
         CMD_FREE_ALL: begin
            for (i = 0; i < HANDLE_DEPTH; i++) if (plan_owner[i] == s) plan_owner[i] = -1;
         end
         default: ;
      endcase
   endtask

   // Driver: holds an item until it is taken, then inserts the next item's planned gap.
   always @(posedge clock) begin : drive_req
      bit load;
      load = 1'b0;
      if (reset) begin
         start <= 1'b0;
         idle_run = 0;
      end else begin
         if (start && !busy) begin
            outcome_q.push_back(table_outcome(req_item));
            load = 1'b1;
         end else if (!start) begin
            load = 1'b1;
         end
         if (load) begin
            if (plan_q.size() != 0 && idle_run >= plan_q[0].gap) begin
               req_item <= plan_q[0].item;
               start    <= 1'b1;
               plan_q.pop_front();
               idle_run = 0;
            end else begin
               start <= 1'b0;
               if (plan_q.size() != 0) idle_run++;
            end
         end
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch_rsp
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (outcome_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_item);
            errors++;
         end else begin
            want = outcome_q.pop_front();
            check_field("owner_session", int'(want.owner_session),
                        int'(rsp_item.owner_session));
            check_field("status", int'(want.status), int'(rsp_item.status));
            check_field("removed_count", int'(want.removed_count),
                        int'(rsp_item.removed_count));
            check_field("pending_left", int'(want.pending_left),
                        int'(rsp_item.pending_left));
         end
      end
   end

   initial begin : watchdog
      wait (cycle_cnt >= RUN_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin : main
      int hot [4];
      int perm [HANDLE_DEPTH];
      int floods;
      int next_flood;
      int occ;
      int r;
      int k;
      int s;
      int h;
      int t;
      int i;
      int j;

      for (i = 0; i < HANDLE_DEPTH; i++) begin
         tbl_valid[i]  = 1'b0;
         tbl_owner[i]  = '0;
         plan_owner[i] = -1;
      end
      for (i = 0; i < SESSION_COUNT; i++) ses_count[i] = 0;

      // Directed part: field extremes, every command and each error case.
      plan_cmd(CMD_ADD, 0, 0);
      plan_cmd(CMD_ADD, 31, 127);
      plan_cmd(CMD_ADD, 5, 0);
      plan_cmd(CMD_ADD, 31, 0);
      plan_cmd(CMD_TAKE, 21, 127);
      plan_cmd(CMD_TAKE, 31, 127);
      plan_cmd(CMD_TAKE, 0, 0);
      plan_cmd(CMD_ADD, 31, 0);
      plan_cmd(CMD_ADD, 31, 64);
      plan_cmd(CMD_ADD, 31, 85);
      plan_cmd(CMD_ADD, 10, 42);
      plan_cmd(CMD_FREE_ALL, 31, 127);
      plan_cmd(CMD_FREE_ALL, 31, 0);
      plan_cmd(CMD_FREE_ALL, 10, 42);
      plan_cmd(CMD_FREE_ALL, 0, 0);
      plan_cmd(2'd3, 0, 0);
      plan_cmd(2'd3, 31, 127);
      plan_cmd(CMD_ADD, 21, 127);
      plan_cmd(CMD_TAKE, 0, 42);
      plan_cmd(CMD_ADD, 21, 1);
      plan_cmd(CMD_FREE_ALL, 21, 5);

      for (i = 0; i < 4; i++) hot[i] = $urandom_range(0, SESSION_COUNT - 1);
      floods     = 0;
      next_flood = plan_q.size() + $urandom_range(0, 100);

      while (plan_q.size() < ITEM_TARGET) begin
         if (floods < 3 && plan_q.size() >= next_flood) begin
            // Empty the table, give every handle to one session, then free it in one scan.
            for (s = 0; s < SESSION_COUNT; s++) begin
               for (i = 0; i < HANDLE_DEPTH && plan_owner[i] != s; i++) ;
               if (i < HANDLE_DEPTH) plan_cmd(CMD_FREE_ALL, s, $urandom_range(0, 127));
            end
            for (i = 0; i < HANDLE_DEPTH; i++) perm[i] = i;
            for (i = HANDLE_DEPTH - 1; i > 0; i--) begin
               j       = $urandom_range(0, i);
               t       = perm[i];
               perm[i] = perm[j];
               perm[j] = t;
            end
            s = $urandom_range(0, SESSION_COUNT - 1);
            for (i = 0; i < HANDLE_DEPTH; i++) plan_cmd(CMD_ADD, s, perm[i]);
            if (floods > 0) begin
               k = $urandom_range(1, 5);
               for (i = 0; i < k; i++) plan_cmd(CMD_TAKE, $urandom_range(0, 31), perm[i]);
            end
            plan_cmd(CMD_FREE_ALL, s, $urandom_range(0, 127));
            floods++;
            next_flood = plan_q.size() + $urandom_range(300, 600);
         end else begin
            if ($urandom_range(0, 99) == 0) hot[$urandom_range(0, 3)] = $urandom_range(0, 31);
            s = ($urandom_range(0, 4) != 0) ? hot[$urandom_range(0, 3)] : $urandom_range(0, 31);
            r = $urandom_range(0, 99);
            if (r < 72) begin
               occ = 0;
               for (i = 0; i < HANDLE_DEPTH; i++) if (plan_owner[i] >= 0) occ++;
               k = $urandom_range(0, 99);
               if (k < 8) begin
                  h = pick_handle(1'b1);
                  plan_cmd(CMD_FREE_ALL, (h >= 0) ? plan_owner[h] : s, $urandom_range(0, 127));
               end else if (k < 8 + ((occ < 20) ? 70 : (occ > 100) ? 25 : 46)) begin
                  h = pick_handle(1'b0);
                  plan_cmd(CMD_ADD, s, (h >= 0) ? h : $urandom_range(0, 127));
               end else begin
                  h = pick_handle(1'b1);
                  plan_cmd(CMD_TAKE, $urandom_range(0, 31),
                           (h >= 0) ? h : $urandom_range(0, 127));
               end
            end else if (r < 90) begin
               plan_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 31),
                        $urandom_range(0, 127));
            end else if (r < 95) begin
               h = pick_handle(1'b1);
               plan_cmd(CMD_ADD, s, (h >= 0) ? h : $urandom_range(0, 127));
            end else begin
               h = pick_handle(1'b0);
               plan_cmd(CMD_TAKE, $urandom_range(0, 31), (h >= 0) ? h : $urandom_range(0, 127));
            end
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (plan_q.size() != 0 || start || outcome_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/prot_pkg.sv
hw/rtl/prot_front.sv
hw/rtl/prot_queue.sv
hw/rtl/prot_back.sv
hw/rtl/pending_request_owner_table_top.sv
bench/tb_top.sv
